@@ sv/cmbp_pkg.sv @@
// shared types, constants and helper functions of the cell map brush painter
`timescale 1ns / 1ps
`default_nettype none

package cmbp_pkg;

   // map geometry
   localparam int MAP_WIDTH  = 320;
   localparam int MAP_HEIGHT = 240;
   localparam int CELLS      = MAP_WIDTH * MAP_HEIGHT;
   localparam int ADDR_W     = (CELLS > 1) ? $clog2(CELLS) : 1;

   // transfer field widths
   localparam int CMD_W    = 2;
   localparam int X_W      = 9;
   localparam int Y_W      = 8;
   localparam int CELL_W   = 8;
   localparam int COLOUR_W = 24;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 32;

   // configuration registers
   localparam int MODE_W     = 2;
   localparam int RADIUS_W   = 6;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 6;
   localparam logic [CSR_IDX_W-1:0] REG_BRUSH_MODE   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_BRUSH_RADIUS = 1'b1;
   localparam logic [MODE_W-1:0]    MODE_RESET   = 2'd0;
   localparam logic [RADIUS_W-1:0]  RADIUS_RESET = 6'd10;

   // internal coordinate arithmetic: holds any map coordinate plus the radius
   localparam int COORD_W = 13;
   localparam int DELTA_W = RADIUS_W + 1;
   localparam int SQ_W    = 2 * RADIUS_W;
   localparam int DIST_W  = SQ_W + 1;
   localparam logic [COORD_W-1:0] X_MAX = COORD_W'(MAP_WIDTH - 1);
   localparam logic [COORD_W-1:0] Y_MAX = COORD_W'(MAP_HEIGHT - 1);

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD  = 2'd0,
      CMD_STAMP = 2'd1,
      CMD_READ  = 2'd2,
      CMD_NONE  = 2'd3
   } cmbp_cmd_type;

   // controller to datapath commands
   typedef struct packed {
      logic clr_wr;
      logic take;
      logic load_wr;
      logic setup;
      logic row_start;
      logic scan;
      logic out_zero;
      logic out_read;
   } cmbp_ctl_type;

   // datapath to controller status
   typedef struct packed {
      logic clr_last;
      logic row_skip;
      logic x_last;
      logic out_free;
   } cmbp_sts_type;

   // linear cell address of a map coordinate
   function automatic logic [ADDR_W-1:0] cell_addr(input logic [COORD_W-1:0] x,
                                                   input logic [COORD_W-1:0] y);
      logic [2*COORD_W-1:0] full;
      full = y * (2*COORD_W)'(MAP_WIDTH) + {{COORD_W{1'b0}}, x};
      return full[ADDR_W-1:0];
   endfunction

   // cell type to display colour
   function automatic logic [COLOUR_W-1:0] palette(input logic [CELL_W-1:0] v);
      logic [COLOUR_W-1:0] c;
      unique case (v)
         8'd0:    c = 24'h0000FF;
         8'd1:    c = 24'h00FF00;
         8'd2:    c = 24'hFFF8DC;
         8'd3:    c = 24'hD2B48C;
         default: c = 24'h000000;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

@@ sv/cmbp_ram.sv @@
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module cmbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                                      clock,
   input  wire logic                                      wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                          wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

@@ sv/cmbp_ctrl.sv @@
// controller state machine of the cell map brush painter
`timescale 1ns / 1ps
`default_nettype none

module cmbp_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   input  wire cmbp_pkg::cmbp_cmd_type req_cmd,
   input  wire cmbp_pkg::cmbp_sts_type sts,
   output logic                       req_tready,
   output cmbp_pkg::cmbp_ctl_type     ctl
);

   import cmbp_pkg::*;

   typedef enum logic [6:0] {
      ST_CLEAR = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_SETUP = 7'b0000100,
      ST_ROW   = 7'b0001000,
      ST_SCAN  = 7'b0010000,
      ST_DONE  = 7'b0100000,
      ST_READ  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   // a new request only when idle and the result slot is free
   assign req_tready = (state_ff == ST_IDLE) && sts.out_free;
   assign accept     = req_tvalid && req_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (sts.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (req_cmd)
                  CMD_STAMP: state_in = ST_SETUP;
                  CMD_READ:  state_in = ST_READ;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_SETUP: state_in = ST_ROW;
         ST_ROW: begin
            state_in = sts.row_skip ? ST_DONE : ST_SCAN;
         end
         ST_SCAN: begin
            if (sts.x_last) state_in = ST_ROW;
         end
         ST_DONE: state_in = ST_IDLE;
         ST_READ: state_in = ST_IDLE;
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath commands
   always_comb begin
      ctl.clr_wr    = (state_ff == ST_CLEAR);
      ctl.take      = accept;
      ctl.load_wr   = accept && (req_cmd == CMD_LOAD);
      ctl.setup     = (state_ff == ST_SETUP);
      ctl.row_start = (state_ff == ST_ROW) && !sts.row_skip;
      ctl.scan      = (state_ff == ST_SCAN);
      ctl.out_zero  = (accept && ((req_cmd == CMD_LOAD) || (req_cmd == CMD_NONE)))
                      || (state_ff == ST_DONE);
      ctl.out_read  = (state_ff == ST_READ);
   end

endmodule

`default_nettype wire

@@ sv/cmbp_dp.sv @@
// datapath: config registers, map memory, brush walk and result register
`timescale 1ns / 1ps
`default_nettype none

module cmbp_dp (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire cmbp_pkg::cmbp_ctl_type          ctl,
   output cmbp_pkg::cmbp_sts_type               sts,
   input  wire logic                            csr_we,
   input  wire logic [cmbp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [cmbp_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  wire logic [cmbp_pkg::X_W-1:0]        req_x,
   input  wire logic [cmbp_pkg::Y_W-1:0]        req_y,
   input  wire logic [cmbp_pkg::CELL_W-1:0]     req_cell,
   input  wire logic                            rsp_tready,
   output logic                                 rsp_tvalid,
   output logic [cmbp_pkg::CELL_W-1:0]          rsp_cell,
   output logic [cmbp_pkg::COLOUR_W-1:0]        rsp_colour
);

   import cmbp_pkg::*;

   logic [MODE_W-1:0]   mode_ff;
   logic [RADIUS_W-1:0] radius_ff;

   logic [COORD_W-1:0]  req_xc, req_yc;
   logic                req_on_map;
   logic [ADDR_W-1:0]   req_addr;

   logic [COORD_W-1:0]  cx_ff, cy_ff;
   logic [COORD_W-1:0]  x0_ff, x1_ff, y1_ff;
   logic [COORD_W-1:0]  xcnt_ff, ycnt_ff;
   logic [ADDR_W-1:0]   row_base_ff;
   logic [SQ_W-1:0]     dy2_ff, r2_ff;
   logic [ADDR_W-1:0]   clr_cnt_ff;
   logic                on_map_ff;

   logic [COORD_W-1:0]  rad_c, x0_in, x1_sum, x1_in, y0_in, y1_sum, y1_in;
   logic [COORD_W-1:0]  dx_full, dy_full;
   logic signed [DELTA_W-1:0]   dx, dy;
   logic signed [2*DELTA_W-1:0] dx_sq, dy_sq;
   logic [DIST_W-1:0]   dist_sq;
   logic                in_disc;

   logic                ram_we;
   logic [ADDR_W-1:0]   ram_waddr;
   logic [CELL_W-1:0]   ram_wdata;
   logic [CELL_W-1:0]   ram_rdata;
   logic [CELL_W-1:0]   brush_val;

   logic                rsp_valid_ff;
   logic [CELL_W-1:0]   rsp_cell_ff;
   logic [COLOUR_W-1:0] rsp_colour_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_RESET;
         radius_ff <= RADIUS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_BRUSH_MODE:   mode_ff   <= csr_wdata[MODE_W-1:0];
            REG_BRUSH_RADIUS: radius_ff <= csr_wdata[RADIUS_W-1:0];
            default:          ;
         endcase
      end
   end

   // request coordinate and address
   assign req_xc     = COORD_W'(req_x);
   assign req_yc     = COORD_W'(req_y);
   assign req_on_map = (req_xc <= X_MAX) && (req_yc <= Y_MAX);
   assign req_addr   = cell_addr(req_xc, req_yc);

   // clipped bounding box of the brush
   assign rad_c  = COORD_W'(radius_ff);
   assign x0_in  = (cx_ff > rad_c) ? (cx_ff - rad_c) : '0;
   assign x1_sum = cx_ff + rad_c;
   assign x1_in  = (x1_sum > X_MAX) ? X_MAX : x1_sum;
   assign y0_in  = (cy_ff > rad_c) ? (cy_ff - rad_c) : '0;
   assign y1_sum = cy_ff + rad_c;
   assign y1_in  = (y1_sum > Y_MAX) ? Y_MAX : y1_sum;

   // offsets from the centre stay within the radius inside the box
   assign dx_full = xcnt_ff - cx_ff;
   assign dy_full = ycnt_ff - cy_ff;
   assign dx      = signed'(dx_full[DELTA_W-1:0]);
   assign dy      = signed'(dy_full[DELTA_W-1:0]);
   assign dx_sq   = dx * dx;
   assign dy_sq   = dy * dy;
   assign dist_sq = {1'b0, dx_sq[SQ_W-1:0]} + {1'b0, dy2_ff};
   assign in_disc = dist_sq < {1'b0, r2_ff};

   assign brush_val = CELL_W'(mode_ff - MODE_W'(1));

   // request latch, box setup and walk counters
   always_ff @(posedge clock) begin
      if (ctl.take) begin
         cx_ff     <= req_xc;
         cy_ff     <= req_yc;
         on_map_ff <= req_on_map;
      end
      if (ctl.setup) begin
         x0_ff   <= x0_in;
         x1_ff   <= x1_in;
         y1_ff   <= y1_in;
         ycnt_ff <= y0_in;
         r2_ff   <= SQ_W'(radius_ff) * SQ_W'(radius_ff);
      end
      if (ctl.row_start) begin
         xcnt_ff     <= x0_ff;
         dy2_ff      <= dy_sq[SQ_W-1:0];
         row_base_ff <= cell_addr('0, ycnt_ff);
      end
      if (ctl.scan) begin
         xcnt_ff <= xcnt_ff + COORD_W'(1);
         if (sts.x_last) begin
            ycnt_ff <= ycnt_ff + COORD_W'(1);
         end
      end
   end

   // clearing pass counter
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (ctl.clr_wr) begin
         clr_cnt_ff <= clr_cnt_ff + ADDR_W'(1);
      end
   end

   // status to the controller
   always_comb begin
      sts.clr_last = (clr_cnt_ff == ADDR_W'(CELLS - 1));
      sts.row_skip = (mode_ff == '0) || (radius_ff == '0) || (x0_ff > x1_ff)
                     || (ycnt_ff > y1_ff);
      sts.x_last   = (xcnt_ff == x1_ff);
      sts.out_free = !rsp_valid_ff || rsp_tready;
   end

   // map memory write select
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = req_addr;
      ram_wdata = req_cell;
      priority if (ctl.clr_wr) begin
         ram_we    = 1'b1;
         ram_waddr = clr_cnt_ff;
         ram_wdata = '0;
      end else if (ctl.scan) begin
         ram_we    = in_disc;
         ram_waddr = row_base_ff + ADDR_W'(xcnt_ff);
         ram_wdata = brush_val;
      end else if (ctl.load_wr) begin
         ram_we    = req_on_map;
      end
   end

   cmbp_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (req_addr),
      .rd_data (ram_rdata)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.out_zero || ctl.out_read) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.out_zero) begin
         rsp_cell_ff   <= '0;
         rsp_colour_ff <= '0;
      end else if (ctl.out_read) begin
         rsp_cell_ff   <= on_map_ff ? ram_rdata : '0;
         rsp_colour_ff <= on_map_ff ? palette(ram_rdata) : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_cell   = rsp_cell_ff;
   assign rsp_colour = rsp_colour_ff;

endmodule

`default_nettype wire

@@ sv/cell_map_brush_painter.sv @@
// top level of the cell map brush painter
`timescale 1ns / 1ps
`default_nettype none

// Keeps a 320 x 240 map of cell bytes and serves three commands on req_tuser:
// load (write one cell), stamp (paint a disc of brush_radius around x, y with
// the value chosen by brush_mode) and read (return the cell and its palette
// colour); every command gives exactly one transfer on rsp. After reset the
// map is cleared one cell per cycle, so req_tready stays low until every
// cell is cleared. Load and the unused command answer straight from the
// result register; read goes through the registered map read first. A stamp
// walks the clipped bounding box row by row through the single map write
// port, one cell per cycle. Configuration writes are taken in any cycle but
// must only happen while no command is pending.
module cell_map_brush_painter (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // requests
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [cmbp_pkg::REQ_DATA_W-1:0]  req_tdata,  // x_pos, y_pos, cell_in
   input  wire logic [cmbp_pkg::CMD_W-1:0]       req_tuser,  // cmd
   // results
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [cmbp_pkg::RSP_DATA_W-1:0]       rsp_tdata,  // cell_out, colour
   // configuration
   input  wire logic                             csr_we,
   input  wire logic [cmbp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [cmbp_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   import cmbp_pkg::*;

   cmbp_ctl_type        ctl;
   cmbp_sts_type        sts;
   cmbp_cmd_type        req_cmd;
   logic [X_W-1:0]      req_x;
   logic [Y_W-1:0]      req_y;
   logic [CELL_W-1:0]   req_cell;
   logic [CELL_W-1:0]   rsp_cell;
   logic [COLOUR_W-1:0] rsp_colour;

   // unpack the request transfer
   assign req_cmd  = cmbp_cmd_type'(req_tuser);
   assign req_x    = req_tdata[X_W-1:0];
   assign req_y    = req_tdata[X_W+Y_W-1:X_W];
   assign req_cell = req_tdata[X_W+Y_W+CELL_W-1:X_W+Y_W];

   cmbp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_cmd    (req_cmd),
      .sts        (sts),
      .req_tready (req_tready),
      .ctl        (ctl)
   );

   cmbp_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .sts        (sts),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_x      (req_x),
      .req_y      (req_y),
      .req_cell   (req_cell),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_cell   (rsp_cell),
      .rsp_colour (rsp_colour)
   );

   // pack the result transfer
   assign rsp_tdata = {rsp_colour, rsp_cell};

`ifndef ASSERT_OFF
   // no request is taken during the clearing pass
   a_no_take_in_clear: assert property (@(posedge clock) disable iff (reset)
      ctl.clr_wr |-> !req_tready)
      else $error("request taken while clearing the map");

   // a request is only taken when the result slot can hold its result
   a_slot_free: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> (!rsp_tvalid || rsp_tready))
      else $error("request taken with result slot occupied");

   // map port users never overlap
   a_port_excl: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctl.clr_wr, ctl.take, ctl.setup, ctl.scan, ctl.out_read}))
      else $error("overlapping datapath commands");

   // a read result is presented the cycle after it is captured
   a_read_shown: assert property (@(posedge clock) disable iff (reset)
      ctl.out_read |=> rsp_tvalid)
      else $error("read result lost");
`endif

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
// self-checking testbench for the cell map brush painter: directed and random command traffic
`timescale 1ns / 1ps

module testbench;
   import cmbp_pkg::*;

   localparam int HALF_PERIOD   = 10;
   localparam int RESET_CYCLES  = 9;
   localparam int STALL_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 20;
   localparam int MAX_REPORTS   = 10;
   localparam int PHASE_COUNT   = 6;
   localparam int PHASE_ITEMS   = 240;
   localparam int STEADY_CHUNK  = 40;
   localparam int X_SPAN        = 1 << X_W;
   localparam int Y_SPAN        = 1 << Y_W;
   localparam int V_SPAN        = 1 << CELL_W;

   // brush modes
   localparam logic [MODE_W-1:0] MODE_OFF   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_WATER = 2'd1;
   localparam logic [MODE_W-1:0] MODE_GREEN = 2'd2;
   localparam logic [MODE_W-1:0] MODE_SOIL  = 2'd3;

   // cell types with a palette entry
   localparam logic [CELL_W-1:0] CELL_WATER = 8'd0;
   localparam logic [CELL_W-1:0] CELL_GREEN = 8'd1;
   localparam logic [CELL_W-1:0] CELL_SOIL  = 8'd2;
   localparam logic [CELL_W-1:0] CELL_TAN   = 8'd3;

   localparam logic [COLOUR_W-1:0] COLOUR_BLUE     = 24'h0000FF;
   localparam logic [COLOUR_W-1:0] COLOUR_GREEN    = 24'h00FF00;
   localparam logic [COLOUR_W-1:0] COLOUR_CORNSILK = 24'hFFF8DC;
   localparam logic [COLOUR_W-1:0] COLOUR_TAN      = 24'hD2B48C;
   localparam logic [COLOUR_W-1:0] COLOUR_BLACK    = 24'h000000;

   typedef struct packed {
      logic [CELL_W-1:0]   cell_value;
      logic [COLOUR_W-1:0] colour;
   } cell_reply_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [CMD_W-1:0]      req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   // predicted map and brush settings
   logic [CELL_W-1:0]   shadow_map [CELLS];
   logic [MODE_W-1:0]   shadow_mode   = MODE_RESET;
   logic [RADIUS_W-1:0] shadow_radius = RADIUS_RESET;

   cell_reply_type expected_replies [$];
   int  mismatch_count = 0;
   int  idle_cycles    = 0;
   int  stall_left     = 0;
   bit  steady         = 1'b0;
   int  brush_x        = 0;
   int  brush_y        = 0;

   cell_map_brush_painter uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // x_pos, y_pos, cell_in
      .req_tuser  (req_tuser),   // cmd
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // cell_out, colour
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // clock
   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   function automatic logic [COLOUR_W-1:0] colour_of(logic [CELL_W-1:0] v);
      case (v)
         CELL_WATER: return COLOUR_BLUE;
         CELL_GREEN: return COLOUR_GREEN;
         CELL_SOIL:  return COLOUR_CORNSILK;
         CELL_TAN:   return COLOUR_TAN;
         default:    return COLOUR_BLACK;
      endcase
   endfunction

   // paint the disc of the current brush, clipped to the map, strict distance compare
   function automatic void paint_disc(int cx, int cy);
      int r, x0, x1, y0, y1;
      logic [CELL_W-1:0] value;
      r = int'(shadow_radius);
      if (shadow_mode == MODE_OFF || r == 0) return;
      // water, green and soil modes write types 0, 1 and 2
      value = CELL_W'(shadow_mode) - 1;
      x0 = (cx - r < 0) ? 0 : cx - r;
      y0 = (cy - r < 0) ? 0 : cy - r;
      x1 = (cx + r > MAP_WIDTH - 1) ? MAP_WIDTH - 1 : cx + r;
      y1 = (cy + r > MAP_HEIGHT - 1) ? MAP_HEIGHT - 1 : cy + r;
      for (int y = y0; y <= y1; y++)
         for (int x = x0; x <= x1; x++)
            if ((x - cx) * (x - cx) + (y - cy) * (y - cy) < r * r)
               shadow_map[y * MAP_WIDTH + x] = value;
   endfunction

   // apply one command to the predicted map and return the reply it gives
   function automatic cell_reply_type predict_reply(cmbp_cmd_type cmd, logic [X_W-1:0] x,
                                                    logic [Y_W-1:0] y, logic [CELL_W-1:0] v);
      cell_reply_type reply;
      bit on_map;
      reply  = '0;
      on_map = (x < MAP_WIDTH) && (y < MAP_HEIGHT);
      case (cmd)
         CMD_LOAD: begin
            if (on_map) shadow_map[int'(y) * MAP_WIDTH + int'(x)] = v;
         end
         CMD_STAMP: begin
            paint_disc(int'(x), int'(y));
         end
         CMD_READ: begin
            if (on_map) begin
               reply.cell_value = shadow_map[int'(y) * MAP_WIDTH + int'(x)];
               reply.colour     = colour_of(reply.cell_value);
            end
         end
         default: ;
      endcase
      return reply;
   endfunction

   function automatic int draw_gap();
      return steady ? 0 : int'($urandom_range(0, 19));
   endfunction

   // one request transfer; valid stays high afterwards unless the next one idles first
   task automatic send_command(cmbp_cmd_type cmd, int x, int y, int v);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= REQ_DATA_W'({CELL_W'(v), Y_W'(y), X_W'(x)});
      do @(posedge clock); while (!req_tready);
      expected_replies.push_back(predict_reply(cmd, X_W'(x), Y_W'(y), CELL_W'(v)));
   endtask

   // stop requesting and wait for every outstanding reply
   task automatic wait_until_drained();
      req_tvalid <= 1'b0;
      while (expected_replies.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] index, int value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_we    <= 1'b0;
      if (index == REG_BRUSH_MODE) shadow_mode = MODE_W'(value);
      else shadow_radius = RADIUS_W'(value);
   endtask

   task automatic set_brush(int mode, int radius);
      write_register(REG_BRUSH_MODE, mode);
      write_register(REG_BRUSH_RADIUS, radius);
   endtask

   // map is all water after reset; off-map reads and the unused command give zeros
   task automatic test_reset_contents();
      send_command(CMD_READ, 0, 0, 0);
      send_command(CMD_READ, MAP_WIDTH - 1, MAP_HEIGHT - 1, 0);
      send_command(CMD_READ, MAP_WIDTH, 0, 0);
      send_command(CMD_READ, X_SPAN - 1, Y_SPAN - 1, V_SPAN - 1);
      send_command(CMD_NONE, 7, 7, V_SPAN - 1);
   endtask

   // loads at the corners, the non-water palette entries and the default colour, off-map loads must not wrap
   task automatic test_load_and_palette();
      send_command(CMD_LOAD, 0, 0, CELL_GREEN);
      send_command(CMD_LOAD, MAP_WIDTH - 1, MAP_HEIGHT - 1, CELL_SOIL);
      send_command(CMD_LOAD, 1, 0, CELL_TAN);
      send_command(CMD_LOAD, 2, 0, V_SPAN - 1);
      send_command(CMD_LOAD, 400, 10, 7);
      send_command(CMD_LOAD, 5, 250, 9);
      send_command(CMD_READ, 0, 0, 0);
      send_command(CMD_READ, MAP_WIDTH - 1, MAP_HEIGHT - 1, 0);
      send_command(CMD_READ, 1, 0, 0);
      send_command(CMD_READ, 2, 0, 0);
      // cells an address wrap of the off-map loads would hit
      send_command(CMD_READ, 80, 11, 0);
      send_command(CMD_READ, 5, 10, 0);
   endtask

   // disc edges, mode off, radius zero and a centre beyond the map
   task automatic test_stamp_shapes();
      wait_until_drained();
      // junk above the mode bits must be dropped
      write_register(REG_BRUSH_MODE, {4'b1011, MODE_SOIL});
      write_register(REG_BRUSH_RADIUS, 5);
      send_command(CMD_STAMP, 100, 100, 0);
      send_command(CMD_READ, 104, 100, 0);
      send_command(CMD_READ, 105, 100, 0);
      send_command(CMD_READ, 103, 104, 0);
      wait_until_drained();
      set_brush(MODE_OFF, 20);
      send_command(CMD_STAMP, 100, 100, 0);
      send_command(CMD_READ, 110, 100, 0);
      wait_until_drained();
      set_brush(MODE_WATER, 0);
      send_command(CMD_STAMP, 100, 100, 0);
      send_command(CMD_READ, 100, 100, 0);
      wait_until_drained();
      set_brush(MODE_GREEN, (1 << RADIUS_W) - 1);
      send_command(CMD_STAMP, 350, 250, 0);
      send_command(CMD_READ, MAP_WIDTH - 1, MAP_HEIGHT - 1, 0);
   endtask

   // one random command, mostly loads and reads around the latest brush centre
   task automatic send_random_command();
      int pick, span, stamp_pct, x, y, v;
      stamp_pct = (shadow_radius > 20) ? 2 : 15;
      span = int'(shadow_radius) + 2;
      x = brush_x + int'($urandom_range(0, 2 * span)) - span;
      y = brush_y + int'($urandom_range(0, 2 * span)) - span;
      x = (x < 0) ? 0 : (x > MAP_WIDTH - 1) ? MAP_WIDTH - 1 : x;
      y = (y < 0) ? 0 : (y > MAP_HEIGHT - 1) ? MAP_HEIGHT - 1 : y;
      v = ($urandom_range(0, 1) == 0) ? int'($urandom_range(0, 4))
                                      : int'($urandom_range(0, V_SPAN - 1));
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
         send_command(CMD_NONE, $urandom_range(0, X_SPAN - 1),
                      $urandom_range(0, Y_SPAN - 1), $urandom_range(0, V_SPAN - 1));
      end else if (pick < 9) begin
         // full-width coordinates, often beyond the map
         send_command(cmbp_cmd_type'(($urandom_range(0, 1) == 0) ? CMD_LOAD : CMD_READ),
                      $urandom_range(0, X_SPAN - 1), $urandom_range(0, Y_SPAN - 1), v);
      end else if (pick < 9 + stamp_pct) begin
         if ($urandom_range(0, 9) == 0) begin
            brush_x = $urandom_range(0, X_SPAN - 1);
            brush_y = $urandom_range(0, Y_SPAN - 1);
         end else begin
            brush_x = $urandom_range(0, MAP_WIDTH - 1);
            brush_y = $urandom_range(0, MAP_HEIGHT - 1);
         end
         send_command(CMD_STAMP, brush_x, brush_y, $urandom_range(0, V_SPAN - 1));
      end else if (pick < 50) begin
         send_command(CMD_LOAD, x, y, v);
      end else begin
         send_command(CMD_READ, x, y, $urandom_range(0, V_SPAN - 1));
      end
   endtask

   // phases of random traffic, each under its own brush setting
   task automatic test_random_traffic();
      int modes [PHASE_COUNT]  = '{MODE_SOIL, MODE_WATER, MODE_GREEN, MODE_OFF,
                                  MODE_SOIL, MODE_GREEN};
      int radii [PHASE_COUNT]  = '{4, (1 << RADIUS_W) - 1, 1, 9, 0, 0};
      radii[PHASE_COUNT-1] = $urandom_range(2, 20);
      brush_x = $urandom_range(0, MAP_WIDTH - 1);
      brush_y = $urandom_range(0, MAP_HEIGHT - 1);
      for (int p = 0; p < PHASE_COUNT; p++) begin
         wait_until_drained();
         set_brush(modes[p], radii[p]);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % STEADY_CHUNK == 0) steady = ($urandom_range(0, 3) == 0);
            send_random_command();
         end
      end
      steady = 1'b0;
   endtask

   function automatic void check_reply(logic [RSP_DATA_W-1:0] data);
      cell_reply_type      want;
      logic [CELL_W-1:0]   got_cell;
      logic [COLOUR_W-1:0] got_colour;
      got_cell   = data[CELL_W-1:0];
      got_colour = data[CELL_W +: COLOUR_W];
      if (expected_replies.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("unexpected result transfer: cell %0d colour %06h", got_cell, got_colour);
      end else begin
         want = expected_replies.pop_front();
         if (got_cell !== want.cell_value || got_colour !== want.colour) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("result mismatch: expected cell %0d colour %06h, got cell %0d colour %06h",
                        want.cell_value, want.colour, got_cell, got_colour);
         end
      end
   endfunction

   // result side: random back-pressure after each transfer, in-order compare
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            check_reply(rsp_tdata);
            stall_left = draw_gap();
            if (stall_left > 0) rsp_tready <= 1'b0;
         end else if (!rsp_tready) begin
            if (stall_left > 0) stall_left--;
            if (stall_left == 0) rsp_tready <= 1'b1;
         end
      end
   end

   // cycles without any transfer
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   initial begin : watchdog
      while (idle_cycles < STALL_LIMIT) @(posedge clock);
      $display("status: fail");
      $finish;
   end

   initial begin : stimulus
      for (int i = 0; i < CELLS; i++) shadow_map[i] = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_reset_contents();
      test_load_and_palette();
      test_stamp_shapes();
      test_random_traffic();

      wait_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_replies.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
